>>> rtl/core/llg_pkg.sv
// ============================================================================
// llg_pkg: shared types and constants for the list label generator
// Format codes, ASCII constants, modulo-999 reciprocal, inter-stage payloads.
// ============================================================================
package llg_pkg;

  // Supported format characters (16-bit codes)
  localparam logic [15:0] CODE_DEC      = 16'h0064;  // 'd'
  localparam logic [15:0] CODE_ALPHA_UP = 16'h0041;  // 'A'
  localparam logic [15:0] CODE_ALPHA_LO = 16'h0061;  // 'a'
  localparam logic [15:0] CODE_ROMAN_UP = 16'h0052;  // 'R'
  localparam logic [15:0] CODE_ROMAN_LO = 16'h0072;  // 'r'

  // Label characters
  localparam logic [6:0] ASC_ZERO = 7'h30;
  localparam logic [6:0] ASC_DOT  = 7'h2E;
  localparam logic [6:0] ASC_UP_A = 7'h41;
  localparam logic [6:0] ASC_LO_A = 7'h61;
  localparam logic [6:0] CASE_BIT = 7'h20;

  // Index wrap and its reciprocal: 2^36 = 999 * RECIP + 1
  localparam int          WRAP        = 999;
  localparam int          RECIP_W     = 27;
  localparam logic [RECIP_W-1:0] RECIP = 27'd68788265;
  localparam int          RECIP_SHIFT = 36;
  localparam int          IDX_W       = 32;
  localparam int          PROD_W      = IDX_W + RECIP_W;
  localparam int          QUOT_W      = PROD_W - RECIP_SHIFT;
  localparam int          N_W         = 10;   // n in 1..999
  localparam int          REM_W       = 11;   // raw remainder below 2*999

  typedef enum logic [2:0] {
    FMT_DEC,
    FMT_ALPHA_UP,
    FMT_ALPHA_LO,
    FMT_ROMAN_UP,
    FMT_ROMAN_LO,
    FMT_BAD
  } fmt_t;

  // Reduced index with decoded format
  typedef struct packed {
    logic [N_W-1:0] n;
    fmt_t           fmt;
  } idx_t;

  // One label segment: up to four characters, first in chars[0]
  typedef struct packed {
    logic [2:0]      len;
    logic [3:0][6:0] chars;
  } seg_t;

  // Whole label: three segments, then the closing dot
  typedef struct packed {
    logic            bad;
    seg_t [2:0]      segs;
  } label_t;

  function automatic fmt_t decode_fmt(input logic [15:0] code);
    fmt_t f;
    unique case (code)
      CODE_DEC:      f = FMT_DEC;
      CODE_ALPHA_UP: f = FMT_ALPHA_UP;
      CODE_ALPHA_LO: f = FMT_ALPHA_LO;
      CODE_ROMAN_UP: f = FMT_ROMAN_UP;
      CODE_ROMAN_LO: f = FMT_ROMAN_LO;
      default:       f = FMT_BAD;
    endcase
    return f;
  endfunction

endpackage

>>> rtl/core/llg_mod999.sv
// ============================================================================
// llg_mod999: three-stage index reduction
// Computes n = (item_number mod 999) + 1 by reciprocal multiply and a single
// correction step; decodes the format code alongside.
// ============================================================================
module llg_mod999 (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [llg_pkg::IDX_W-1:0]       item_number,
  input  logic [15:0]                     format_code,
  output logic                            out_valid,
  input  logic                            out_ready,
  output llg_pkg::idx_t                   out_data
);

  localparam int RW = llg_pkg::REM_W;
  localparam int PW = llg_pkg::PROD_W;
  localparam int QW = llg_pkg::QUOT_W;
  localparam int MW = QW + llg_pkg::N_W;

  logic                 s1_v, s2_v, s3_v;
  logic                 rdy1, rdy2, rdy3;
  logic [PW-1:0]        s1_prod;
  logic [RW-1:0]        s1_xlo, s2_xlo, s2_qm_lo;
  llg_pkg::fmt_t        s1_fmt, s2_fmt, s3_fmt;
  logic [llg_pkg::N_W-1:0] s3_n;

  logic [MW-1:0]        qm_full;
  logic [RW-1:0]        r_raw, r_fix;

  // Stall chain
  assign rdy3     = !s3_v || out_ready;
  assign rdy2     = !s2_v || rdy3;
  assign rdy1     = !s1_v || rdy2;
  assign in_ready = rdy1;

  // Quotient estimate times 999, and the corrected remainder
  assign qm_full = MW'(s1_prod[PW-1:llg_pkg::RECIP_SHIFT]) * MW'(llg_pkg::WRAP);
  assign r_raw   = s2_xlo - s2_qm_lo;
  assign r_fix   = (r_raw >= RW'(llg_pkg::WRAP)) ? r_raw - RW'(llg_pkg::WRAP) : r_raw;

  // Valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      s2_v <= 1'b0;
      s3_v <= 1'b0;
    end else begin
      if (rdy1) s1_v <= in_valid;
      if (rdy2) s2_v <= s1_v;
      if (rdy3) s3_v <= s2_v;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (rdy1) begin
      s1_prod <= PW'(item_number) * PW'(llg_pkg::RECIP);
      s1_xlo  <= item_number[RW-1:0];
      s1_fmt  <= llg_pkg::decode_fmt(format_code);
    end
    if (rdy2) begin
      s2_qm_lo <= qm_full[RW-1:0];
      s2_xlo   <= s1_xlo;
      s2_fmt   <= s1_fmt;
    end
    if (rdy3) begin
      s3_n   <= r_fix[llg_pkg::N_W-1:0] + llg_pkg::N_W'(1);
      s3_fmt <= s2_fmt;
    end
  end

  assign out_valid    = s3_v;
  assign out_data.n   = s3_n;
  assign out_data.fmt = s3_fmt;

endmodule

>>> rtl/core/llg_digits.sv
// ============================================================================
// llg_digits: five-stage digit split and label segment build
// Splits n into decimal digits and bijective base-26 letters with constant
// reciprocal multiplies, then maps them to character segments.
// ============================================================================
module llg_digits (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  llg_pkg::idx_t   in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output llg_pkg::label_t out_label
);

  localparam int NW = llg_pkg::N_W;

  // Roman numeral part for one decimal digit, given the unit, five and ten
  function automatic llg_pkg::seg_t roman_part(input logic [3:0] dig,
                                               input logic [6:0] one,
                                               input logic [6:0] five,
                                               input logic [6:0] ten);
    llg_pkg::seg_t s;
    s = '0;
    case (dig)
      4'd1: begin s.len = 3'd1; s.chars[0] = one; end
      4'd2: begin s.len = 3'd2; s.chars[0] = one; s.chars[1] = one; end
      4'd3: begin
        s.len = 3'd3; s.chars[0] = one; s.chars[1] = one; s.chars[2] = one;
      end
      4'd4: begin s.len = 3'd2; s.chars[0] = one; s.chars[1] = five; end
      4'd5: begin s.len = 3'd1; s.chars[0] = five; end
      4'd6: begin s.len = 3'd2; s.chars[0] = five; s.chars[1] = one; end
      4'd7: begin
        s.len = 3'd3; s.chars[0] = five; s.chars[1] = one; s.chars[2] = one;
      end
      4'd8: begin
        s.len = 3'd4; s.chars[0] = five; s.chars[1] = one;
        s.chars[2] = one; s.chars[3] = one;
      end
      4'd9: begin s.len = 3'd2; s.chars[0] = one; s.chars[1] = ten; end
      default: s.len = 3'd0;
    endcase
    return s;
  endfunction

  logic v1, v2, v3, v4, v5;
  logic r1, r2, r3, r4, r5;

  // Stage payloads
  logic [NW-1:0]  d1_n, d1_d, d2_d, d3_d;
  logic [3:0]     d1_h, d2_h, d3_h, d4_h;
  logic [1:0]     d1_len, d2_len, d3_len, d4_len;
  llg_pkg::fmt_t  d1_fmt, d2_fmt, d3_fmt, d4_fmt;
  logic [6:0]     d2_rem, d3_rem;
  logic [4:0]     d2_a1, d3_a1, d4_a1, d4_a0;
  logic [3:0]     d3_t, d4_t, d4_o;
  llg_pkg::label_t d5_label;

  // Combinational per-stage terms
  logic [15:0]    nh;
  logic [1:0]     len_c;
  logic [NW-1:0]  d_c, h100, a26, d_diff;
  logic [21:0]    ad;
  logic [14:0]    rt;
  logic [6:0]     t10, o_diff;
  llg_pkg::label_t lab;

  assign r5       = !v5 || out_ready;
  assign r4       = !v4 || r5;
  assign r3       = !v3 || r4;
  assign r2       = !v2 || r3;
  assign r1       = !v1 || r2;
  assign in_ready = r1;

  // Stage 1: hundreds estimate, letter count and letter offset
  assign nh = 16'(in_data.n) * 16'd41;
  always_comb begin
    if (in_data.n <= NW'(26)) begin
      len_c = 2'd1;
      d_c   = in_data.n - NW'(1);
    end else if (in_data.n <= NW'(702)) begin
      len_c = 2'd2;
      d_c   = in_data.n - NW'(27);
    end else begin
      len_c = 2'd3;
      d_c   = in_data.n - NW'(703);
    end
  end

  // Stage 2 terms: remainder below 100, upper letter
  assign h100 = NW'(d1_h) * NW'(100);
  assign ad   = 22'(d1_d) * 22'd2521;

  // Stage 3 terms: tens digit, lower letter
  assign rt     = 15'(d2_rem) * 15'd205;
  assign a26    = NW'(d2_a1) * NW'(26);
  assign d_diff = d2_d - a26;

  // Stage 4 terms: ones digit
  assign t10    = 7'(d3_t) * 7'd10;
  assign o_diff = d3_rem - t10;

  // Stage 5: segment build
  always_comb begin
    logic [6:0] base;
    logic [3:0] o;
    lab  = '0;
    o    = d4_o;
    base = (d4_fmt == llg_pkg::FMT_ALPHA_UP) ? llg_pkg::ASC_UP_A : llg_pkg::ASC_LO_A;
    lab.bad = (d4_fmt == llg_pkg::FMT_BAD);
    case (d4_fmt) inside
      llg_pkg::FMT_DEC: begin
        lab.segs[0].len      = {2'b00, d4_h != 4'd0};
        lab.segs[0].chars[0] = llg_pkg::ASC_ZERO + 7'(d4_h);
        lab.segs[1].len      = {2'b00, (d4_h != 4'd0) || (d4_t != 4'd0)};
        lab.segs[1].chars[0] = llg_pkg::ASC_ZERO + 7'(d4_t);
        lab.segs[2].len      = 3'd1;
        lab.segs[2].chars[0] = llg_pkg::ASC_ZERO + 7'(o);
      end
      llg_pkg::FMT_ALPHA_UP, llg_pkg::FMT_ALPHA_LO: begin
        // Three-letter labels stay below 703 + 676, so the top letter is A
        lab.segs[0].len      = {2'b00, d4_len == 2'd3};
        lab.segs[0].chars[0] = base;
        lab.segs[1].len      = {2'b00, d4_len != 2'd1};
        lab.segs[1].chars[0] = base + 7'(d4_a1);
        lab.segs[2].len      = 3'd1;
        lab.segs[2].chars[0] = base + 7'(d4_a0);
      end
      llg_pkg::FMT_ROMAN_UP, llg_pkg::FMT_ROMAN_LO: begin
        lab.segs[0] = roman_part(d4_h, 7'h63, 7'h64, 7'h6D);  // c d m
        lab.segs[1] = roman_part(d4_t, 7'h78, 7'h6C, 7'h63);  // x l c
        lab.segs[2] = roman_part(o,    7'h69, 7'h76, 7'h78);  // i v x
        if (d4_fmt == llg_pkg::FMT_ROMAN_UP) begin
          for (int s = 0; s < 3; s++) begin
            for (int c = 0; c < 4; c++) begin
              lab.segs[s].chars[c] = lab.segs[s].chars[c] & ~llg_pkg::CASE_BIT;
            end
          end
        end
      end
      default: ;
    endcase
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      if (r1) v1 <= in_valid;
      if (r2) v2 <= v1;
      if (r3) v3 <= v2;
      if (r4) v4 <= v3;
      if (r5) v5 <= v4;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (r1) begin
      d1_n   <= in_data.n;
      d1_h   <= nh[15:12];
      d1_d   <= d_c;
      d1_len <= len_c;
      d1_fmt <= in_data.fmt;
    end
    if (r2) begin
      d2_rem <= 7'(d1_n - h100);
      d2_a1  <= ad[20:16];
      d2_h   <= d1_h;
      d2_d   <= d1_d;
      d2_len <= d1_len;
      d2_fmt <= d1_fmt;
    end
    if (r3) begin
      d3_t   <= rt[14:11];
      d3_a1  <= d2_a1;
      d3_d   <= d_diff;
      d3_rem <= d2_rem;
      d3_h   <= d2_h;
      d3_len <= d2_len;
      d3_fmt <= d2_fmt;
    end
    if (r4) begin
      d4_a0  <= d3_d[4:0];
      d4_a1  <= d3_a1;
      d4_o   <= o_diff[3:0];
      d4_t   <= d3_t;
      d4_h   <= d3_h;
      d4_len <= d3_len;
      d4_fmt <= d3_fmt;
    end
    if (r5) begin
      d5_label <= lab;
    end
  end

  assign out_valid = v5;
  assign out_label = d5_label;

endmodule

>>> rtl/core/llg_serializer.sv
// ============================================================================
// llg_serializer: label to character stream
// Holds one label and walks its segments, one character per transfer, with
// a registered output; the next label loads as the last character leaves.
// ============================================================================
module llg_serializer (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  llg_pkg::label_t in_label,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [6:0]      label_char,
  output logic            last_char,
  output logic            bad_format
);

  localparam logic [1:0] SEG_DOT = 2'd3;

  // First non-empty segment at or after start, else the dot
  function automatic logic [1:0] first_seg(input logic [2:0] start,
                                           input llg_pkg::seg_t [2:0] segs);
    logic [1:0] sel;
    logic       found;
    sel   = SEG_DOT;
    found = 1'b0;
    for (int i = 0; i < 3; i++) begin
      if (!found && (3'(i) >= start) && (segs[i].len != 3'd0)) begin
        sel   = 2'(i);
        found = 1'b1;
      end
    end
    return sel;
  endfunction

  logic            hold_v;
  llg_pkg::label_t hold;
  logic [1:0]      pos_seg, pos_ch;
  logic [1:0]      pos_seg_next, pos_ch_next;

  logic            emit;
  logic            cur_last;
  logic [6:0]      cur_char;

  assign emit     = hold_v && (!out_valid || out_ready);
  assign cur_last = hold.bad || (pos_seg == SEG_DOT);
  assign in_ready = !hold_v || (emit && cur_last);

  // Character at the current position
  always_comb begin
    if (hold.bad) begin
      cur_char = 7'd0;
    end else if (pos_seg == SEG_DOT) begin
      cur_char = llg_pkg::ASC_DOT;
    end else begin
      cur_char = hold.segs[pos_seg].chars[pos_ch];
    end
  end

  // Advance within a segment, or on to the next non-empty one
  always_comb begin
    pos_seg_next = pos_seg;
    pos_ch_next  = pos_ch;
    if (pos_seg != SEG_DOT) begin
      if (({1'b0, pos_ch} + 3'd1) < hold.segs[pos_seg].len) begin
        pos_ch_next = pos_ch + 2'd1;
      end else begin
        pos_seg_next = first_seg({1'b0, pos_seg} + 3'd1, hold.segs);
        pos_ch_next  = 2'd0;
      end
    end
  end

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_v    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) hold_v <= 1'b1;
      else if (emit && cur_last) hold_v <= 1'b0;
      if (emit) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  // Held label, position and output register
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      hold    <= in_label;
      pos_seg <= first_seg(3'd0, in_label.segs);
      pos_ch  <= 2'd0;
    end else if (emit) begin
      pos_seg <= pos_seg_next;
      pos_ch  <= pos_ch_next;
    end
    if (emit) begin
      label_char <= cur_char;
      last_char  <= cur_last;
      bad_format <= hold.bad;
    end
  end

endmodule

>>> rtl/core/list_label_generator_core.sv
// ============================================================================
// list_label_generator_core: list item label generator
// Reduces an item index modulo 999 and streams its decimal, letter or Roman
// label one ASCII character per transfer, closed by a dot.
// ============================================================================
// Between the input transfer and out_valid lie the three reduction stages,
// the five digit stages, the serializer's held label and its output register.
// Throughput: one character per cycle while out_ready stays high; a label has
// 2 to 13 characters with its dot, 1 for a bad format. The 3 + 5 pipeline
// stages keep taking items while the serializer streams, until they fill.
// Reset: synchronous, clears all valid bits; no clearing pass is needed.
module list_label_generator_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] item_number,
  input  logic [15:0] format_code,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [6:0]  label_char,
  output logic        last_char,
  output logic        bad_format
);

  logic            mod_valid, mod_ready;
  llg_pkg::idx_t   mod_data;
  logic            dig_valid, dig_ready;
  llg_pkg::label_t dig_label;

  // Index reduction
  llg_mod999 u_mod999 (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .item_number (item_number),
    .format_code (format_code),
    .out_valid   (mod_valid),
    .out_ready   (mod_ready),
    .out_data    (mod_data)
  );

  // Digit split and segment build
  llg_digits u_digits (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (mod_valid),
    .in_ready  (mod_ready),
    .in_data   (mod_data),
    .out_valid (dig_valid),
    .out_ready (dig_ready),
    .out_label (dig_label)
  );

  // Character stream
  llg_serializer u_serializer (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (dig_valid),
    .in_ready   (dig_ready),
    .in_label   (dig_label),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .label_char (label_char),
    .last_char  (last_char),
    .bad_format (bad_format)
  );

  // Reduced index always lands in 1..999
  a_n_range: assert property (@(posedge clk) disable iff (rst)
    mod_valid |-> (mod_data.n >= 10'd1) && (mod_data.n <= 10'd999))
    else $error("reduced index out of range");

  // A stalled label between pipeline and serializer holds
  a_label_hold: assert property (@(posedge clk) disable iff (rst)
    dig_valid && !dig_ready |=> dig_valid && $stable(dig_label))
    else $error("label changed while stalled");

  // Bad format gives a single zero character marked last
  a_bad_single: assert property (@(posedge clk) disable iff (rst)
    out_valid && bad_format |-> last_char && (label_char == 7'd0))
    else $error("bad format result malformed");

  // A good label always closes with the dot
  a_last_dot: assert property (@(posedge clk) disable iff (rst)
    out_valid && !bad_format && last_char |-> label_char == llg_pkg::ASC_DOT)
    else $error("label not closed by dot");

endmodule
